// ----- hw/rtl/mvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types, codes and helpers for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // Default sizing handed to the top level.
  localparam int DEF_MAX_VOICES    = 16;
  localparam int DEF_MAX_CLIPS     = 64;
  localparam int DEF_SAMPLE_FRAMES = 65536;

  // Fixed widths and limits of the interface.
  localparam int              ACC_W        = 26;
  localparam logic [15:0]     UNITY_Q15    = 16'h8000;
  localparam logic [16:0]     MAX_CLIP_LEN = 17'd65536;
  localparam int              MIX_W        = 21;

  // Action codes carried on the input channel.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_CLIP  = 2'd1,
    ACT_PLAY  = 2'd2,
    ACT_TICK  = 2'd3
  } act_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_HDL = 2'd2;
  localparam logic [1:0] ST_TOO_BIG = 2'd3;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_WR_RED,
    S_WR_DO,
    S_P_SCAN,
    S_T_VOICE,
    S_T_CLIP,
    S_T_CHECK,
    S_T_MUL,
    S_T_ACC,
    S_T_WB,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap;
    logic       red_step;
    logic       wr_samp;
    logic       add_clip;
    logic       claim;
    logic       st_load;
    logic [1:0] st_code;
    logic       vi_clr;
    logic       vi_inc;
    logic       chk;
    logic       mul;
    logic       acc;
    logic       wb;
    logic       fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    act_t op;
    logic red_done;
    logic bad_handle;
    logic vact_cur;
    logic vi_last;
    logic skip;
    logic out_free;
  } sts_t;

  // Saturate the accumulator to the 21-bit signed output range.
  function automatic logic [MIX_W-1:0] sat_mix(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(22'sd1048575));
    lo = ACC_W'(signed'(-22'sd1048576));
    if (a > hi) begin
      return hi[MIX_W-1:0];
    end else if (a < lo) begin
      return lo[MIX_W-1:0];
    end
    return a[MIX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/multi_voice_sample_mixer.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Stereo sample-playback mixer with a clip table and a bank of voices.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A sample write runs the compare-and-subtract
// steps that bring the address into the sample memory depth (the default
// depth needs one step). Add clip, and play with a bad handle, go straight
// from decode to the result. A play scans the voice slots one per cycle from
// slot 0 and claims the first idle one, or reports full when every slot is
// busy. A tick walks every voice slot in turn: an idle slot is passed over,
// a slot that adds nothing (a one-shot past its clip end, or a looping voice
// on an empty clip) skips the multiply and accumulate steps, and a playing
// slot goes through the chain of registered voice, clip and sample memory
// reads and the multiplier stage. A further beat is taken while the result
// waits in the output register; the result is held until it can be handed
// on.
module multi_voice_sample_mixer import mvsm_pkg::*; #(
  parameter int MAX_VOICES    = DEF_MAX_VOICES,
  parameter int MAX_CLIPS     = DEF_MAX_CLIPS,
  parameter int SAMPLE_FRAMES = DEF_SAMPLE_FRAMES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic [15:0]             in_address,
  input  logic signed [15:0]      in_sample_left,
  input  logic signed [15:0]      in_sample_right,
  input  logic [16:0]             in_clip_length,
  input  logic [6:0]              in_clip_handle,
  input  logic [15:0]             in_voice_gain,
  input  logic                    in_loop_enable,
  input  logic                    in_block_end,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [6:0]              out_new_handle,
  output logic signed [MIX_W-1:0] out_mix_left,
  output logic signed [MIX_W-1:0] out_mix_right
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  mvsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores and arithmetic.
  mvsm_datapath #(
    .MAX_VOICES    (MAX_VOICES),
    .MAX_CLIPS     (MAX_CLIPS),
    .SAMPLE_FRAMES (SAMPLE_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_clip_length  (in_clip_length),
    .in_clip_handle  (in_clip_handle),
    .in_voice_gain   (in_voice_gain),
    .in_loop_enable  (in_loop_enable),
    .in_block_end    (in_block_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_new_handle  (out_new_handle),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right)
  );

endmodule

// ----- hw/rtl/mvsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvsm_ctrl
// Sequencer for the mixer: decodes each beat and steps the datapath.
// ----------------------------------------------------------------------------
module mvsm_ctrl import mvsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (sts.op)
          ACT_WRITE: state_nxt = S_WR_RED;
          ACT_CLIP:  state_nxt = S_FIN;
          ACT_PLAY:  state_nxt = sts.bad_handle ? S_FIN : S_P_SCAN;
          ACT_TICK:  state_nxt = S_T_VOICE;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_WR_RED: begin
        if (sts.red_done) state_nxt = S_WR_DO;
      end
      S_WR_DO: state_nxt = S_FIN;
      S_P_SCAN: begin
        if (!sts.vact_cur || sts.vi_last) state_nxt = S_FIN;
      end
      S_T_VOICE: begin
        if (sts.vact_cur) begin
          state_nxt = S_T_CLIP;
        end else if (sts.vi_last) begin
          state_nxt = S_FIN;
        end
      end
      S_T_CLIP:  state_nxt = S_T_CHECK;
      S_T_CHECK: state_nxt = sts.skip ? S_T_WB : S_T_MUL;
      S_T_MUL:   state_nxt = S_T_ACC;
      S_T_ACC:   state_nxt = S_T_WB;
      S_T_WB:    state_nxt = sts.vi_last ? S_FIN : S_T_VOICE;
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.cap = in_valid;
      S_DEC: begin
        unique case (sts.op)
          ACT_CLIP: cmd.add_clip = 1'b1;
          ACT_PLAY: begin
            if (sts.bad_handle) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_BAD_HDL;
            end else begin
              cmd.vi_clr = 1'b1;
            end
          end
          ACT_TICK: cmd.vi_clr = 1'b1;
          default: ;
        endcase
      end
      S_WR_RED: cmd.red_step = 1'b1;
      S_WR_DO:  cmd.wr_samp  = 1'b1;
      S_P_SCAN: begin
        if (!sts.vact_cur) begin
          cmd.claim = 1'b1;
        end else if (sts.vi_last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_FULL;
        end else begin
          cmd.vi_inc = 1'b1;
        end
      end
      S_T_VOICE: begin
        if (!sts.vact_cur && !sts.vi_last) cmd.vi_inc = 1'b1;
      end
      S_T_CLIP:  ;
      S_T_CHECK: cmd.chk = 1'b1;
      S_T_MUL:   cmd.mul = 1'b1;
      S_T_ACC:   cmd.acc = 1'b1;
      S_T_WB: begin
        cmd.wb     = 1'b1;
        cmd.vi_inc = !sts.vi_last;
      end
      S_FIN: cmd.fin = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/mvsm_datapath.sv -----
// ----------------------------------------------------------------------------
// mvsm_datapath
// Sample, clip and voice stores, the mix multipliers and the result register.
// ----------------------------------------------------------------------------
module mvsm_datapath import mvsm_pkg::*; #(
  parameter int MAX_VOICES    = DEF_MAX_VOICES,
  parameter int MAX_CLIPS     = DEF_MAX_CLIPS,
  parameter int SAMPLE_FRAMES = DEF_SAMPLE_FRAMES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_action,
  input  logic [15:0]             in_address,
  input  logic signed [15:0]      in_sample_left,
  input  logic signed [15:0]      in_sample_right,
  input  logic [16:0]             in_clip_length,
  input  logic [6:0]              in_clip_handle,
  input  logic [15:0]             in_voice_gain,
  input  logic                    in_loop_enable,
  input  logic                    in_block_end,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [6:0]              out_new_handle,
  output logic signed [MIX_W-1:0] out_mix_left,
  output logic signed [MIX_W-1:0] out_mix_right
);

  localparam int AW  = $clog2(SAMPLE_FRAMES);
  localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CIW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
  localparam int CCW = $clog2(MAX_CLIPS + 1);
  localparam int RW  = 22;
  localparam int RED_STEPS = (SAMPLE_FRAMES >= 65536) ? 1 : (17 - $clog2(SAMPLE_FRAMES));

  // Captured beat.
  act_t               act_r;
  logic [15:0]        addr_r;
  logic [15:0]        sl_r, sr_r;
  logic [16:0]        len_r;
  logic [6:0]         hdl_r;
  logic [15:0]        gain_r;
  logic               loop_r, bend_r;

  // Write address reduction.
  logic [15:0]        red_addr_r;
  logic [2:0]         red_k_r;
  logic [RW-1:0]      red_thr;

  // Configuration and bookkeeping.
  logic [15:0]        master_r;
  logic [15:0]        mvc;
  logic [CCW-1:0]     ccnt_r;
  logic [VIW-1:0]     vi_r;
  logic               vact_r [MAX_VOICES];

  // Stores.
  logic [31:0]        smem [SAMPLE_FRAMES];
  logic [15:0]        cbase_m [MAX_CLIPS];
  logic [16:0]        cfr_m [MAX_CLIPS];
  logic [CIW-1:0]     vclip_m [MAX_VOICES];
  logic [16:0]        vcur_m [MAX_VOICES];
  logic [15:0]        vlev_m [MAX_VOICES];
  logic               vrep_m [MAX_VOICES];

  // Registered read data.
  logic [31:0]        sdata_r;
  logic [15:0]        cbase_q;
  logic [16:0]        cfr_q;
  logic [CIW-1:0]     vclip_q;
  logic [16:0]        vcur_q;
  logic [15:0]        vlev_q;
  logic               vrep_q;

  // Mix pipeline.
  logic               hit_end, skip;
  logic [16:0]        cur_eff;
  logic [AW-1:0]      srd_addr;
  logic [16:0]        ncur_r, lenc_r;
  logic [31:0]        g_r;
  logic signed [32:0] g_s;
  logic signed [47:0] prod_l_r, prod_r_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;

  // Result staging and output register.
  logic [1:0]         res_st_r;
  logic [6:0]         res_hdl_r;
  logic               out_valid_r;
  logic [1:0]         out_st_r;
  logic [6:0]         out_hdl_r;
  logic [MIX_W-1:0]   out_ml_r, out_mr_r;

  logic               clip_full, clip_over;

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r  <= act_t'(in_action);
      addr_r <= in_address;
      sl_r   <= in_sample_left;
      sr_r   <= in_sample_right;
      len_r  <= in_clip_length;
      hdl_r  <= in_clip_handle;
      gain_r <= in_voice_gain;
      loop_r <= in_loop_enable;
      bend_r <= in_block_end;
    end
  end

  // Master volume register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= UNITY_Q15;
    end else if (cfg_wr_en) begin
      master_r <= cfg_wr_data;
    end
  end

  assign mvc = (master_r > UNITY_Q15) ? UNITY_Q15 : master_r;

  // Restoring reduction of the write address modulo the sample memory depth.
  assign red_thr = RW'(SAMPLE_FRAMES) << red_k_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      red_addr_r <= in_address;
      red_k_r    <= 3'(RED_STEPS - 1);
    end else if (cmd.red_step) begin
      if (RW'(red_addr_r) >= red_thr) red_addr_r <= red_addr_r - red_thr[15:0];
      if (red_k_r != 3'd0) red_k_r <= red_k_r - 3'd1;
    end
  end

  // Sample memory.
  always_ff @(posedge clk) begin
    if (cmd.wr_samp) smem[AW'(red_addr_r)] <= {sr_r, sl_r};
  end

  always_ff @(posedge clk) begin
    sdata_r <= smem[srd_addr];
  end

  // Clip table.
  assign clip_full = (ccnt_r >= CCW'(MAX_CLIPS));
  assign clip_over = (len_r > MAX_CLIP_LEN) ||
                     ((RW'(addr_r) + RW'(len_r)) > RW'(SAMPLE_FRAMES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
    end else if (cmd.add_clip && !clip_full && !clip_over) begin
      ccnt_r <= ccnt_r + CCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_clip && !clip_full && !clip_over) begin
      cbase_m[ccnt_r[CIW-1:0]] <= addr_r;
      cfr_m[ccnt_r[CIW-1:0]]   <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    cbase_q <= cbase_m[vclip_q];
    cfr_q   <= cfr_m[vclip_q];
  end

  // Voice slot index.
  always_ff @(posedge clk) begin
    if (cmd.vi_clr) begin
      vi_r <= '0;
    end else if (cmd.vi_inc) begin
      vi_r <= vi_r + VIW'(1);
    end
  end

  // Voice active bits: set on claim, cleared when a finished one-shot is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_VOICES; i++) vact_r[i] <= 1'b0;
    end else if (cmd.claim) begin
      vact_r[vi_r] <= 1'b1;
    end else if (cmd.wb && bend_r && !vrep_q && (ncur_r >= lenc_r)) begin
      vact_r[vi_r] <= 1'b0;
    end
  end

  // Voice store.
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      vclip_m[vi_r] <= CIW'(hdl_r - 7'd1);
      vcur_m[vi_r]  <= '0;
      vlev_m[vi_r]  <= (gain_r > UNITY_Q15) ? UNITY_Q15 : gain_r;
      vrep_m[vi_r]  <= loop_r;
    end else if (cmd.wb) begin
      vcur_m[vi_r]  <= ncur_r;
    end
  end

  always_ff @(posedge clk) begin
    vclip_q <= vclip_m[vi_r];
    vcur_q  <= vcur_m[vi_r];
    vlev_q  <= vlev_m[vi_r];
    vrep_q  <= vrep_m[vi_r];
  end

  // End-of-clip handling and the sample read address.
  assign hit_end  = (vcur_q >= cfr_q);
  assign skip     = hit_end && (!vrep_q || (cfr_q == 17'd0));
  assign cur_eff  = hit_end ? 17'd0 : vcur_q;
  assign srd_addr = AW'(18'(cbase_q) + 18'(cur_eff));

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      ncur_r <= skip ? vcur_q : (cur_eff + 17'd1);
      lenc_r <= cfr_q;
      g_r    <= {16'b0, vlev_q} * {16'b0, mvc};
    end
  end

  // Product of each sample with the combined gain.
  assign g_s = {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= 48'(signed'(sdata_r[15:0])) * 48'(g_s);
      prod_r_r <= 48'(signed'(sdata_r[31:16])) * 48'(g_s);
    end
  end

  // Accumulate floor(product / 2^30).
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (cmd.acc) begin
      acc_l_r <= acc_l_r + ACC_W'(signed'(prod_l_r[47:30]));
      acc_r_r <= acc_r_r + ACC_W'(signed'(prod_r_r[47:30]));
    end
  end

  // Result status and handle.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      res_st_r  <= ST_OK;
      res_hdl_r <= 7'd0;
    end else if (cmd.add_clip) begin
      if (clip_full) begin
        res_st_r <= ST_FULL;
      end else if (clip_over) begin
        res_st_r <= ST_TOO_BIG;
      end else begin
        res_hdl_r <= 7'(ccnt_r + CCW'(1));
      end
    end else if (cmd.st_load) begin
      res_st_r <= cmd.st_code;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_st_r  <= res_st_r;
      out_hdl_r <= res_hdl_r;
      out_ml_r  <= sat_mix(acc_l_r);
      out_mr_r  <= sat_mix(acc_r_r);
    end
  end

  // Status to the controller.
  always_comb begin
    sts.op         = act_r;
    sts.red_done   = (red_k_r == 3'd0);
    sts.bad_handle = (hdl_r == 7'd0) || (9'(hdl_r) > 9'(ccnt_r));
    sts.vact_cur   = vact_r[vi_r];
    sts.vi_last    = (vi_r == VIW'(MAX_VOICES - 1));
    sts.skip       = skip;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_st_r;
  assign out_new_handle = out_hdl_r;
  assign out_mix_left   = out_ml_r;
  assign out_mix_right  = out_mr_r;

endmodule

// ----- hw/rtl/mvsm_checker.sv -----
// ----------------------------------------------------------------------------
// mvsm_checker
// Port-level checks on the mixer's result channel.
// ----------------------------------------------------------------------------
module mvsm_checker import mvsm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_status,
  input logic [6:0]              out_new_handle,
  input logic signed [MIX_W-1:0] out_mix_left,
  input logic signed [MIX_W-1:0] out_mix_right
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_new_handle) && $stable(out_mix_left) && $stable(out_mix_right))
    else $error("stalled result beat changed");

  // An error status carries no handle and no mix.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_new_handle == 7'd0 && out_mix_left == '0 && out_mix_right == '0)
    else $error("error result carries data");

  // A handle is only given with an ok status and a silent mix.
  a_hdl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_handle != 7'd0 |->
      out_status == ST_OK && out_mix_left == '0 && out_mix_right == '0)
    else $error("handle result carries mix data");

  // A result is not shown in the cycle after reset.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_chk (.*);
